/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the easing interpolator rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define QEI_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define QEI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qei_pkg.sv */
// ---------------------------------------------------------------------------
// qei_pkg
// shared constants, register indexes and control types of the easing engine
// ---------------------------------------------------------------------------
package qei_pkg;

  localparam int POSITION_WIDTH_DEF = 16;
  localparam int DURATION_WIDTH_DEF = 16;
  localparam int FRACTION_BITS_DEF  = 16;

  localparam int REG_INDEX_WIDTH = 2;
  localparam int MODE_WIDTH      = 2;

  // configuration register indexes
  localparam logic [REG_INDEX_WIDTH-1:0] REG_START_VALUE = 2'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_END_VALUE   = 2'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_DURATION    = 2'd2;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_CURVE_MODE  = 2'd3;

  // curve modes, the unused codes run as in-out
  localparam logic [MODE_WIDTH-1:0] MODE_EASE_IN  = 2'd0;
  localparam logic [MODE_WIDTH-1:0] MODE_EASE_OUT = 2'd1;

  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic shape_mul;
    logic curve;
    logic scale_mul;
    logic round;
    logic load_out;
  } qei_cmd_t;

  typedef struct packed {
    logic early;
    logic out_free;
  } qei_status_t;

endpackage

/* rtl/qei_ctrl.sv */
// ---------------------------------------------------------------------------
// qei_ctrl
// sequencer: tick update, serial division, curve multiply, scale, output
// ---------------------------------------------------------------------------
module qei_ctrl import qei_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  qei_status_t status,
  output qei_cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SHAPE,
    ST_CURVE,
    ST_SCALE,
    ST_ROUND,
    ST_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] bit_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      bit_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_CHECK;
        end
        ST_CHECK: begin
          bit_cnt <= '0;
          // idle curve or end reached: no arithmetic needed
          state   <= status.early ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == CNT_W'(FRACTION_BITS - 1)) state <= ST_SHAPE;
        end
        ST_SHAPE: state <= ST_CURVE;
        ST_CURVE: state <= ST_SCALE;
        ST_SCALE: state <= ST_ROUND;
        ST_ROUND: state <= ST_OUT;
        ST_OUT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.accept    = (state == ST_IDLE) && in_valid;
    cmd.div_init  = (state == ST_CHECK);
    cmd.div_step  = (state == ST_DIV);
    cmd.shape_mul = (state == ST_SHAPE);
    cmd.curve     = (state == ST_CURVE);
    cmd.scale_mul = (state == ST_SCALE);
    cmd.round     = (state == ST_ROUND);
    cmd.load_out  = (state == ST_OUT) && status.out_free;
  end

endmodule

/* rtl/qei_datapath.sv */
// ---------------------------------------------------------------------------
// qei_datapath
// config registers, tick counter, restoring divider, curve and scale math
// ---------------------------------------------------------------------------
module qei_datapath import qei_pkg::*; #(
  parameter int  POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int  DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int  FRACTION_BITS  = FRACTION_BITS_DEF,
  localparam int CFG_W = (POSITION_WIDTH > DURATION_WIDTH) ? POSITION_WIDTH : DURATION_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [REG_INDEX_WIDTH-1:0]       cfg_addr,
  input  logic [CFG_W-1:0]                 cfg_wdata,
  input  logic                             restart,
  input  qei_cmd_t                         cmd,
  output qei_status_t                      status,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [POSITION_WIDTH-1:0] position,
  output logic                             finished
);

  localparam int P  = POSITION_WIDTH;
  localparam int D  = DURATION_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int SW = P + F + 3;

  localparam logic [F:0]   ONE_Q = (F+1)'(1) << F;
  localparam logic [F+1:0] TWO_Q = (F+2)'(1) << (F + 1);

  logic signed [P-1:0] start_value;
  logic signed [P-1:0] end_value;
  logic [D-1:0]        duration;
  logic [MODE_WIDTH-1:0] curve_mode;

  logic [D-1:0] elapsed;
  logic         running;
  logic [D:0]   rem;
  logic [F-1:0] quo;

  logic [2*F+1:0]       shape_prod;
  logic [F:0]           ease;
  logic signed [SW-1:0] scale_prod;
  logic [P-1:0]         delta;

  logic [D-1:0]         dur_eff;
  logic                 at_end;
  logic [D:0]           rem_sh;
  logic                 rem_ge;
  logic [F:0]           u_w;
  logic                 hi_half;
  logic [F-1:0]         op_a;
  logic [F+1:0]         op_b;
  logic [F:0]           ease_next;
  logic signed [P:0]    diff;
  logic signed [SW-1:0] biased;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= '0;
      end_value   <= '0;
      duration    <= D'(1);
      curve_mode  <= MODE_EASE_IN;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_VALUE: start_value <= cfg_wdata[P-1:0];
        REG_END_VALUE:   end_value   <= cfg_wdata[P-1:0];
        REG_DURATION:    duration    <= cfg_wdata[D-1:0];
        REG_CURVE_MODE:  curve_mode  <= cfg_wdata[MODE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // zero duration runs as one tick
  assign dur_eff = (duration == '0) ? D'(1) : duration;
  assign at_end  = (elapsed >= dur_eff);

  assign status.early    = !running || at_end;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      running <= 1'b0;
    end else if (cmd.accept) begin
      if (restart) begin
        elapsed <= '0;
        running <= 1'b1;
      end else if (running && !at_end) begin
        elapsed <= elapsed + 1'b1;
      end
    end
  end

  // restoring division of elapsed * 2^F by duration, one quotient bit a cycle
  assign rem_sh = {rem[D-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, dur_eff});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= {1'b0, elapsed};
    end else if (cmd.div_step) begin
      rem <= rem_ge ? (rem_sh - {1'b0, dur_eff}) : rem_sh;
      quo <= {quo[F-2:0], rem_ge};
    end
  end

  // curve operands, quo holds t from here on
  assign u_w     = ONE_Q - {1'b0, quo};
  assign hi_half = curve_mode[1] && quo[F-1];
  assign op_a    = hi_half ? u_w[F-1:0] : quo;

  always_comb begin
    unique case (curve_mode)
      MODE_EASE_IN:  op_b = {2'b00, quo};
      MODE_EASE_OUT: op_b = TWO_Q - {2'b00, quo};
      default:       op_b = {2'b00, op_a};
    endcase
  end

  always_comb begin
    unique case (curve_mode)
      MODE_EASE_IN, MODE_EASE_OUT: ease_next = shape_prod[2*F:F];
      default: begin
        // in-out doubles the square; upper half mirrors around one
        if (quo[F-1]) ease_next = ONE_Q - shape_prod[2*F-1:F-1];
        else          ease_next = shape_prod[2*F-1:F-1];
      end
    endcase
  end

  assign diff = {end_value[P-1], end_value} - {start_value[P-1], start_value};

  // truncate toward zero: bias negative products before the shift
  assign biased = scale_prod + (scale_prod[SW-1] ? SW'(ONE_Q - 1'b1) : SW'(0));

  always_ff @(posedge clk) begin
    if (cmd.shape_mul) shape_prod <= (2*F+2)'(op_a) * (2*F+2)'(op_b);
    if (cmd.curve)     ease       <= ease_next;
    if (cmd.scale_mul) scale_prod <= SW'(diff) * SW'($signed({1'b0, ease}));
    if (cmd.round)     delta      <= biased[F+P-1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      finished <= running && at_end;
      if (!running)    position <= start_value;
      else if (at_end) position <= end_value;
      else             position <= start_value + $signed(delta);
    end
  end

endmodule

/* rtl/quadratic_easing_interpolator.sv */
// ---------------------------------------------------------------------------
// quadratic_easing_interpolator
// quadratic ease-in / ease-out / in-out position generator, one word per tick
// ---------------------------------------------------------------------------
//  channel   dir  fields (lsb first)                    handshake
//  s_axis    in   tdata: restart                        tvalid/tready
//  m_axis    out  tdata: position, finished             tvalid/tready
//  cfg       in   start, end, duration, curve_mode      cfg_we, no wait
//
//  a running tick passes check, the serial restoring divider (one quotient
//  bit a cycle), shape, curve, scale, round and out before ready again;
//  a tick before the first restart or past the end goes from check to out.
//  the next tick is accepted while a result still waits on m_axis; the
//  sequencer then holds its last step until the output register is free.
//  rst is synchronous: counter stopped, config registers back to defaults.
// ---------------------------------------------------------------------------
module quadratic_easing_interpolator import qei_pkg::*; #(
  parameter int  POSITION_WIDTH = POSITION_WIDTH_DEF,
  parameter int  DURATION_WIDTH = DURATION_WIDTH_DEF,
  parameter int  FRACTION_BITS  = FRACTION_BITS_DEF,
  localparam int CFG_W = (POSITION_WIDTH > DURATION_WIDTH) ? POSITION_WIDTH : DURATION_WIDTH,
  localparam int OUT_W = ((POSITION_WIDTH + 1 + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [REG_INDEX_WIDTH-1:0] cfg_addr,
  input  logic [CFG_W-1:0]           cfg_wdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // restart
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [OUT_W-1:0]           m_axis_tdata    // position, finished
);

  `include "assert_macros.svh"

  qei_cmd_t    cmd;
  qei_status_t status;

  logic signed [POSITION_WIDTH-1:0] position;
  logic                             finished;

  qei_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  qei_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .DURATION_WIDTH (DURATION_WIDTH),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .restart   (s_axis_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .position  (position),
    .finished  (finished)
  );

  assign m_axis_tdata = OUT_W'({finished, position});

  `QEI_ASSERT_NEXT(a_accept_blocks, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready after accept")
  `QEI_ASSERT_IMPL(a_load_when_free, cmd.load_out, !m_axis_tvalid || m_axis_tready, "output overwritten")
  `QEI_ASSERT_NEXT(a_load_shows, cmd.load_out, m_axis_tvalid, "loaded word not shown")

endmodule
